@@ sv/cknms_pkg.sv @@
`timescale 1ns / 1ps
package cknms_pkg;

    localparam int IMAGE_DIM     = 1024;
    localparam int COORD_W       = $clog2(IMAGE_DIM);
    localparam int RESP_W        = 8;
    localparam int DIAM_W        = 6;
    localparam int MAX_KEYPOINTS = 64;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RESPONSE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KP_DIAMETER  = 1'b1;

    localparam logic [RESP_W-1:0] MIN_RESPONSE_RST = 8'd100;
    localparam logic [DIAM_W-1:0] KP_DIAMETER_RST  = 6'd6;

    // candidate queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [RESP_W-1:0]  resp;
        logic               is_cand;
        logic               fend;
    } t_cand;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [RESP_W-1:0]  resp;
    } t_entry;

    typedef struct packed {
        logic [COORD_W-1:0] kp_row;
        logic [COORD_W-1:0] kp_col;
        logic [RESP_W-1:0]  kp_response;
        logic               kp_valid;
        logic               kp_last;
        logic               table_overflow;
    } t_kp;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_START,
        BK_SCAN,
        BK_DRD,
        BK_DOUT
    } t_bk_state;

endpackage

@@ sv/cknms_ifs.sv @@
`timescale 1ns / 1ps
interface cknms_pix_if;
    logic                           valid;
    logic                           ready;
    logic [cknms_pkg::COORD_W-1:0]  pixel_row;
    logic [cknms_pkg::COORD_W-1:0]  pixel_col;
    logic [cknms_pkg::RESP_W-1:0]   pixel_response;
    logic                           frame_end;

    modport source (output valid, pixel_row, pixel_col, pixel_response, frame_end,
                    input ready);
    modport sink   (input valid, pixel_row, pixel_col, pixel_response, frame_end,
                    output ready);
endinterface

interface cknms_kp_if;
    logic                           valid;
    logic                           ready;
    logic [cknms_pkg::COORD_W-1:0]  kp_row;
    logic [cknms_pkg::COORD_W-1:0]  kp_col;
    logic [cknms_pkg::RESP_W-1:0]   kp_response;
    logic                           kp_valid;
    logic                           kp_last;
    logic                           table_overflow;

    modport source (output valid, kp_row, kp_col, kp_response, kp_valid, kp_last,
                    table_overflow, input ready);
    modport sink   (input valid, kp_row, kp_col, kp_response, kp_valid, kp_last,
                    table_overflow, output ready);
endinterface

@@ sv/corner_keypoint_nms_table_unit.sv @@
`timescale 1ns / 1ps
// Greedy non-maximum suppression of corner keypoints.
// i_pix takes response pixels in raster order (valid/ready); o_kp gives the
// kept keypoints of a frame after the pixel marked frame_end, the final beat
// with kp_last set. An empty frame gives one beat with kp_valid low.
// The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) sets min_response
// and keypoint_diameter; write it only while the block is idle.
// A pixel at or below the threshold is dropped unless it marks frame end.
// Candidates go through a four-beat queue to the table engine, which scans
// the table one entry per cycle through a three-stage read/square/compare
// pipeline on the single table read port. After the frame-end pixel's own
// candidate work, readout alternates a read and an output state per entry.
// Reset (synchronous, active low) empties the table and the queue, clears the
// overflow flag and restores min_response 100 and diameter 6. A stalled
// receiver holds the readout; the queue then fills and i_pix.ready drops.
module corner_keypoint_nms_table_unit #(
    parameter int MAX_KEYPOINTS = cknms_pkg::MAX_KEYPOINTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    cknms_pix_if.sink                         i_pix,
    cknms_kp_if.source                        o_kp,
    input  logic                              i_cfg_we,
    input  logic [cknms_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cknms_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [cknms_pkg::RESP_W-1:0]  r_min_response;
    logic [cknms_pkg::DIAM_W-1:0]  r_diameter;

    logic              w_push_valid, w_push_ready;
    cknms_pkg::t_cand  w_push_data;
    logic              w_pop_valid, w_pop_ready;
    cknms_pkg::t_cand  w_pop_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_response <= cknms_pkg::MIN_RESPONSE_RST;
            r_diameter     <= cknms_pkg::KP_DIAMETER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cknms_pkg::CFG_MIN_RESPONSE: begin
                    r_min_response <= i_cfg_data[cknms_pkg::RESP_W-1:0];
                end
                cknms_pkg::CFG_KP_DIAMETER: begin
                    r_diameter <= i_cfg_data[cknms_pkg::DIAM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    cknms_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pix          (i_pix),
        .i_min_response (r_min_response),
        .o_push_valid   (w_push_valid),
        .o_push_data    (w_push_data),
        .i_push_ready   (w_push_ready)
    );

    cknms_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_data  (w_push_data),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_data   (w_pop_data),
        .i_pop_ready  (w_pop_ready)
    );

    cknms_back #(
        .MAX_KEYPOINTS (MAX_KEYPOINTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .i_pop_data  (w_pop_data),
        .o_pop_ready (w_pop_ready),
        .i_diameter  (r_diameter),
        .o_kp        (o_kp)
    );

endmodule

@@ sv/cknms_front.sv @@
`timescale 1ns / 1ps
module cknms_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cknms_pix_if.sink                     i_pix,
    input  logic [cknms_pkg::RESP_W-1:0]  i_min_response,
    output logic                          o_push_valid,
    output cknms_pkg::t_cand              o_push_data,
    input  logic                          i_push_ready
);

    logic             r_vld;
    cknms_pkg::t_cand r_item;
    logic             w_keep;
    logic             w_acc;

    assign i_pix.ready = !r_vld || i_push_ready;
    assign w_acc       = i_pix.valid && i_pix.ready;
    // pixels at or below threshold without frame end vanish here
    assign w_keep      = (i_pix.pixel_response > i_min_response) || i_pix.frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_acc) begin
            r_vld <= w_keep;
        end else if (i_push_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item.row     <= i_pix.pixel_row;
            r_item.col     <= i_pix.pixel_col;
            r_item.resp    <= i_pix.pixel_response;
            r_item.is_cand <= i_pix.pixel_response > i_min_response;
            r_item.fend    <= i_pix.frame_end;
        end
    end

    assign o_push_valid = r_vld;
    assign o_push_data  = r_item;

endmodule

@@ sv/cknms_queue.sv @@
`timescale 1ns / 1ps
module cknms_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    input  cknms_pkg::t_cand  i_push_data,
    output logic              o_push_ready,
    output logic              o_pop_valid,
    output cknms_pkg::t_cand  o_pop_data,
    input  logic              i_pop_ready
);

    cknms_pkg::t_cand                  r_mem [cknms_pkg::QDEPTH];
    logic [cknms_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [cknms_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [cknms_pkg::QCNT_W-1:0]      r_cnt;
    logic                              w_push;
    logic                              w_pop;

    assign o_push_ready = r_cnt != cknms_pkg::QCNT_W'(cknms_pkg::QDEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

@@ sv/cknms_back.sv @@
`timescale 1ns / 1ps
module cknms_back #(
    parameter int MAX_KEYPOINTS = cknms_pkg::MAX_KEYPOINTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_pop_valid,
    input  cknms_pkg::t_cand              i_pop_data,
    output logic                          o_pop_ready,
    input  logic [cknms_pkg::DIAM_W-1:0]  i_diameter,
    cknms_kp_if.source                    o_kp
);

    localparam int IW = (MAX_KEYPOINTS > 1) ? $clog2(MAX_KEYPOINTS) : 1;
    localparam int CW = $clog2(MAX_KEYPOINTS + 1);
    localparam int CWD = cknms_pkg::COORD_W;
    localparam int SQW = 2 * CWD;
    localparam int D2W = 2 * cknms_pkg::DIAM_W;

    cknms_pkg::t_entry      r_mem [MAX_KEYPOINTS];
    cknms_pkg::t_entry      r_rd;

    cknms_pkg::t_bk_state   r_state, n_state;
    cknms_pkg::t_cand       r_item, n_item;
    logic [CW-1:0]          r_count, n_count;
    logic                   r_ovf, n_ovf;
    logic                   r_ovl, n_ovl;
    logic [CW-1:0]          r_rd_idx, n_rd_idx;
    logic [CW-1:0]          r_dump_idx, n_dump_idx;
    logic                   r_p1_vld, n_p1_vld;
    logic [IW-1:0]          r_p1_idx, n_p1_idx;
    logic                   r_p2_vld, n_p2_vld;
    logic [IW-1:0]          r_p2_idx;
    logic [SQW-1:0]         r_sq_r, r_sq_c;
    logic                   r_gt;
    logic [D2W-1:0]         r_d2;
    logic                   r_out_vld, n_out_vld;
    cknms_pkg::t_kp         r_out, n_out;

    logic                   wr_en, rd_en;
    logic [IW-1:0]          wr_addr, rd_addr;
    logic [CWD-1:0]         w_dr, w_dc;
    logic [SQW:0]           w_dist2;
    logic                   w_ovl, w_hit, w_last, w_done, w_dlast;
    cknms_pkg::t_bk_state   w_after;

    // squared distance of the entry in stage 2
    assign w_dr    = (r_item.row >= r_rd.row) ? r_item.row - r_rd.row : r_rd.row - r_item.row;
    assign w_dc    = (r_item.col >= r_rd.col) ? r_item.col - r_rd.col : r_rd.col - r_item.col;
    assign w_dist2 = (SQW + 1)'(r_sq_r) + (SQW + 1)'(r_sq_c);
    assign w_ovl   = w_dist2 < (SQW + 1)'(r_d2);
    assign w_hit   = w_ovl && r_gt;
    assign w_last  = (CW'(r_p2_idx) + CW'(1)) == r_count;
    assign w_dlast = (r_dump_idx + CW'(1)) == r_count;
    assign w_after = r_item.fend ? cknms_pkg::BK_DRD : cknms_pkg::BK_IDLE;

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_ovl      = r_ovl;
        n_rd_idx   = r_rd_idx;
        n_dump_idx = r_dump_idx;
        n_p1_vld   = 1'b0;
        n_p1_idx   = r_p1_idx;
        n_p2_vld   = 1'b0;
        n_out_vld  = r_out_vld && !o_kp.ready;
        n_out      = r_out;
        wr_en      = 1'b0;
        wr_addr    = r_p2_idx;
        rd_en      = 1'b0;
        rd_addr    = r_rd_idx[IW-1:0];
        o_pop_ready = 1'b0;
        w_done     = 1'b0;

        case (r_state)
            cknms_pkg::BK_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop_valid) begin
                    n_item  = i_pop_data;
                    n_state = cknms_pkg::BK_START;
                end
            end
            cknms_pkg::BK_START: begin
                n_dump_idx = '0;
                if (r_item.is_cand && r_count == '0) begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    n_count = CW'(1);
                    n_state = w_after;
                end else if (r_item.is_cand) begin
                    n_rd_idx = '0;
                    n_ovl    = 1'b0;
                    n_state  = cknms_pkg::BK_SCAN;
                end else begin
                    n_state = w_after;
                end
            end
            cknms_pkg::BK_SCAN: begin
                if (r_rd_idx < r_count) begin
                    rd_en    = 1'b1;
                    n_p1_vld = 1'b1;
                    n_p1_idx = r_rd_idx[IW-1:0];
                    n_rd_idx = r_rd_idx + CW'(1);
                end
                n_p2_vld = r_p1_vld;
                if (r_p2_vld) begin
                    n_ovl = r_ovl || w_ovl;
                    if (w_hit) begin
                        wr_en  = 1'b1;
                        w_done = 1'b1;
                    end else if (w_last) begin
                        w_done = 1'b1;
                        if (!(r_ovl || w_ovl)) begin
                            if (r_count < CW'(MAX_KEYPOINTS)) begin
                                wr_en   = 1'b1;
                                wr_addr = r_count[IW-1:0];
                                n_count = r_count + CW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                    end
                end
                if (w_done) begin
                    // reads still in flight are dropped
                    n_p1_vld = 1'b0;
                    n_p2_vld = 1'b0;
                    n_state  = w_after;
                end
            end
            cknms_pkg::BK_DRD: begin
                rd_en   = 1'b1;
                rd_addr = r_dump_idx[IW-1:0];
                n_state = cknms_pkg::BK_DOUT;
            end
            cknms_pkg::BK_DOUT: begin
                if (!r_out_vld || o_kp.ready) begin
                    n_out_vld            = 1'b1;
                    n_out.table_overflow = r_ovf;
                    if (r_count == '0) begin
                        n_out.kp_row      = '0;
                        n_out.kp_col      = '0;
                        n_out.kp_response = '0;
                        n_out.kp_valid    = 1'b0;
                        n_out.kp_last     = 1'b1;
                    end else begin
                        n_out.kp_row      = r_rd.row;
                        n_out.kp_col      = r_rd.col;
                        n_out.kp_response = r_rd.resp;
                        n_out.kp_valid    = 1'b1;
                        n_out.kp_last     = w_dlast;
                    end
                    if (r_count == '0 || w_dlast) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = cknms_pkg::BK_IDLE;
                    end else begin
                        n_dump_idx = r_dump_idx + CW'(1);
                        n_state    = cknms_pkg::BK_DRD;
                    end
                end
            end
            default: begin
                n_state = cknms_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cknms_pkg::BK_IDLE;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_p1_vld  <= n_p1_vld;
            r_p2_vld  <= n_p2_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_ovl      <= n_ovl;
        r_rd_idx   <= n_rd_idx;
        r_dump_idx <= n_dump_idx;
        r_p1_idx   <= n_p1_idx;
        r_out      <= n_out;
        r_d2       <= i_diameter * i_diameter;
        // stage 1: squares and response compare
        r_sq_r     <= w_dr * w_dr;
        r_sq_c     <= w_dc * w_dc;
        r_gt       <= r_item.resp > r_rd.resp;
        r_p2_idx   <= r_p1_idx;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= {r_item.row, r_item.col, r_item.resp};
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    assign o_kp.valid          = r_out_vld;
    assign o_kp.kp_row         = r_out.kp_row;
    assign o_kp.kp_col         = r_out.kp_col;
    assign o_kp.kp_response    = r_out.kp_response;
    assign o_kp.kp_valid       = r_out.kp_valid;
    assign o_kp.kp_last        = r_out.kp_last;
    assign o_kp.table_overflow = r_out.table_overflow;

endmodule
